>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/msp_pkg.sv
// types, codes and the status length decode for the midi stream parser
`timescale 1ns / 1ps

package msp_pkg;

   localparam logic [1:0] KIND_SHORT    = 2'd0;
   localparam logic [1:0] KIND_REALTIME = 2'd1;
   localparam logic [1:0] KIND_SYSEX    = 2'd2;

   localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
   localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
   localparam logic [7:0] BYTE_NO_STATUS    = 8'h00;

   localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
   localparam logic [3:0] HI_NOTE_ON    = 4'h9;
   localparam logic [3:0] HI_POLY_PRESS = 4'hA;
   localparam logic [3:0] HI_CTRL       = 4'hB;
   localparam logic [3:0] HI_PROG       = 4'hC;
   localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
   localparam logic [3:0] HI_PITCH      = 4'hE;
   localparam logic [3:0] HI_SYSTEM     = 4'hF;

   localparam logic [3:0] LO_TIME_CODE  = 4'h1;
   localparam logic [3:0] LO_SONG_POS   = 4'h2;
   localparam logic [3:0] LO_SONG_SEL   = 4'h3;

   localparam logic [1:0] LEN_NONE  = 2'd0;
   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   localparam int RESULT_SLOTS = 3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] msg_kind;
      logic       msg_first;
      logic       msg_last;
      logic       run_last;
   } msp_result_type;

   function automatic logic [1:0] msp_status_len(input logic [7:0] s);
      logic [1:0] len;
      len = LEN_ONE;
      unique case (s[7:4])
         HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CTRL, HI_PITCH: len = LEN_THREE;
         HI_PROG, HI_CHAN_PRESS: len = LEN_TWO;
         HI_SYSTEM: begin
            if (s[3:0] == LO_TIME_CODE || s[3:0] == LO_SONG_SEL) begin
               len = LEN_TWO;
            end else if (s[3:0] == LO_SONG_POS) begin
               len = LEN_THREE;
            end else begin
               len = LEN_ONE;
            end
         end
         default: len = LEN_ONE;
      endcase
      return len;
   endfunction

endpackage

>>> sv/midi_stream_parser.sv
// first result of an accepted byte is shown in the cycle after it is taken
// one byte per cycle while each byte yields at most one result and rsp_stall is low
// a byte that completes a short message yields two or three results, one a cycle
// unless stalled, from the result queue; input stalls until its last result is taken
// reset (synchronous, active high) clears parser state and drops queued results
`timescale 1ns / 1ps

module midi_stream_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_msg_kind,
   output logic       rsp_msg_first,
   output logic       rsp_msg_last,
   output logic       rsp_run_last
);
   import msp_pkg::*;

   logic       in_sysex_ff, in_sysex_in;
   logic [7:0] status_ff, status_in;
   logic [1:0] exp_len_ff, exp_len_in;
   logic       data_cnt_ff, data_cnt_in;
   logic [6:0] held_ff, held_in;

   msp_result_type res_ff [RESULT_SLOTS];
   msp_result_type res_in [RESULT_SLOTS];
   msp_result_type new_res [RESULT_SLOTS];
   logic [1:0] new_cnt;
   logic [1:0] cnt_ff, cnt_in;

   logic       req_acc;
   logic       rsp_acc;
   logic [2:0] fill_sum;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign req_stall = (cnt_ff > 2'd1) || ((cnt_ff == 2'd1) && rsp_stall);
   assign req_acc   = req_valid && !req_stall;

   assign rsp_out_byte  = res_ff[0].out_byte;
   assign rsp_msg_kind  = res_ff[0].msg_kind;
   assign rsp_msg_first = res_ff[0].msg_first;
   assign rsp_msg_last  = res_ff[0].msg_last;
   assign rsp_run_last  = res_ff[0].run_last;

   assign fill_sum = {2'b00, data_cnt_ff} + 3'd2;

   // parse one byte against the current state
   always_comb begin
      in_sysex_in = in_sysex_ff;
      status_in   = status_ff;
      exp_len_in  = exp_len_ff;
      data_cnt_in = data_cnt_ff;
      held_in     = held_ff;
      new_cnt     = 2'd0;
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         new_res[i] = '0;
      end
      priority if (req_in_byte >= BYTE_REALTIME_MIN) begin
         new_res[0] = '{req_in_byte, KIND_REALTIME, 1'b1, 1'b1, 1'b1};
         new_cnt    = 2'd1;
      end else if (in_sysex_ff) begin
         new_res[0] = '{req_in_byte, KIND_SYSEX, 1'b0,
                        req_in_byte == BYTE_SYSEX_END, 1'b1};
         new_cnt    = 2'd1;
         if (req_in_byte == BYTE_SYSEX_END) begin
            in_sysex_in = 1'b0;
         end
      end else if (req_in_byte == BYTE_SYSEX_START) begin
         in_sysex_in = 1'b1;
         status_in   = BYTE_NO_STATUS;
         exp_len_in  = LEN_NONE;
         data_cnt_in = 1'b0;
         held_in     = '0;
         new_res[0]  = '{req_in_byte, KIND_SYSEX, 1'b1, 1'b0, 1'b1};
         new_cnt     = 2'd1;
      end else if (req_in_byte[7]) begin
         data_cnt_in = 1'b0;
         held_in     = '0;
         if (msp_status_len(req_in_byte) == LEN_ONE) begin
            status_in  = BYTE_NO_STATUS;
            exp_len_in = LEN_NONE;
            new_res[0] = '{req_in_byte, KIND_SHORT, 1'b1, 1'b1, 1'b1};
            new_cnt    = 2'd1;
         end else begin
            status_in  = req_in_byte;
            exp_len_in = msp_status_len(req_in_byte);
         end
      end else if (status_ff == BYTE_NO_STATUS) begin
         new_cnt = 2'd0;
      end else if (fill_sum >= {1'b0, exp_len_ff}) begin
         new_res[0] = '{status_ff, KIND_SHORT, 1'b1, 1'b0, 1'b0};
         if (data_cnt_ff) begin
            new_res[1] = '{{1'b0, held_ff}, KIND_SHORT, 1'b0, 1'b0, 1'b0};
            new_res[2] = '{req_in_byte, KIND_SHORT, 1'b0, 1'b1, 1'b1};
            new_cnt    = 2'd3;
         end else begin
            new_res[1] = '{req_in_byte, KIND_SHORT, 1'b0, 1'b1, 1'b1};
            new_cnt    = 2'd2;
         end
         data_cnt_in = 1'b0;
         held_in     = '0;
      end else begin
         held_in     = req_in_byte[6:0];
         data_cnt_in = 1'b1;
      end
   end

   // result queue: load on accept, shift down on each taken result
   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (req_acc) begin
         res_in = new_res;
         cnt_in = new_cnt;
      end else if (rsp_acc) begin
         for (int i = 0; i < RESULT_SLOTS - 1; i++) begin
            res_in[i] = res_ff[i + 1];
         end
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sysex_ff <= 1'b0;
         status_ff   <= BYTE_NO_STATUS;
         exp_len_ff  <= LEN_NONE;
         data_cnt_ff <= 1'b0;
         held_ff     <= '0;
         cnt_ff      <= 2'd0;
      end else begin
         if (req_acc) begin
            in_sysex_ff <= in_sysex_in;
            status_ff   <= status_in;
            exp_len_ff  <= exp_len_in;
            data_cnt_ff <= data_cnt_in;
            held_ff     <= held_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

>>> sv/msp_checker.sv
// port level checks for the midi stream parser and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_msg_kind,
   input logic       rsp_msg_first,
   input logic       rsp_msg_last,
   input logic       rsp_run_last
);
   import msp_pkg::*;

   // a stalled result item holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_msg_kind) && $stable(rsp_msg_first) && $stable(rsp_msg_last) && $stable(rsp_run_last), "stalled result item changed")

   // realtime is a whole one-byte message
   `ASSERT_IMPLY(a_rt_whole, clock, reset, rsp_valid && rsp_msg_kind == KIND_REALTIME, rsp_msg_first && rsp_msg_last && rsp_run_last && rsp_out_byte >= BYTE_REALTIME_MIN, "realtime item malformed")

   // sysex ends only on its end byte
   `ASSERT_IMPLY(a_sysex_end, clock, reset, rsp_valid && rsp_msg_kind == KIND_SYSEX && rsp_msg_last, rsp_out_byte == BYTE_SYSEX_END, "sysex end on wrong byte")

   // a short message opens with a status byte
   `ASSERT_IMPLY(a_short_first, clock, reset, rsp_valid && rsp_msg_kind == KIND_SHORT && rsp_msg_first, rsp_out_byte[7], "short message without status")

endmodule

bind midi_stream_parser msp_checker u_msp_checker (.*);
